>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console cell writer
// Field widths, command codes, blank and prompt cell values and the
// sequencer state and micro-operation types.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEWLINE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BACK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ENTER   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

	localparam logic [BYTE_W-1:0] BLANK_CODE  = 8'h20;
	localparam logic [BYTE_W-1:0] PROMPT_CODE = 8'h24;
	localparam logic [BYTE_W-1:0] PROMPT_ATTR = 8'h04;
	localparam logic [BYTE_W-1:0] ATTR_RESET  = 8'h07;

	localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, BLANK_CODE};

	// Enter runs four micro-operations; the step counter walks them.
	localparam logic [1:0] ENTER_LAST_STEP = 2'd3;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_SWEEP,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACK,
		OP_CLEAR,
		OP_READ,
		OP_NONE
	} op_t;

endpackage

>>> rtl/tcw_ifs.sv
// ----------------------------------------------------------------------------
// tcw_ifs: command and result channels of the text console cell writer
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] char_code;
	logic [BYTE_W-1:0] char_attribute;
	logic [ROW_W-1:0]  read_row;
	logic [COL_W-1:0]  read_column;

	modport source (
		output valid, cmd, char_code, char_attribute, read_row, read_column,
		input  ready
	);
	modport sink (
		input  valid, cmd, char_code, char_attribute, read_row, read_column,
		output ready
	);
endinterface

interface tcw_res_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row_now;
	logic [COL_W-1:0]  column_now;
	logic [CELL_W-1:0] cell_value;

	modport source (
		output valid, row_now, column_now, cell_value,
		input  ready
	);
	modport sink (
		input  valid, row_now, column_now, cell_value,
		output ready
	);
endinterface

>>> rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer: text console cell store with cursor
// Cell store, cursor and command sequencer of a character text console.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the command channel when valid and
// ready are both high; exactly one result item (cursor row and column after
// the command, and the cell read by a read command, else zero) leaves on the
// result channel. Ready is high only while the sequencer is idle, so one
// command is in work at a time. The cell store is a RAM with a registered
// read; a single address unit (row rotate, multiply by the row length, add
// column) serves every cursor and read access, while sweeps step the address
// up. Scrolling does not move cells: a top-row pointer rotates and only the
// freed row is blanked. Ready returns in the cycle after the result is loaded
// into the output register.
// After reset the sequencer sweeps all ROWS*COLUMNS cells to blank them, with
// ready low; the attribute register can be written during that time. A stalled
// receiver holds the result in the output register; the next command may be
// accepted meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tcw_cmd_if.sink                command,
	tcw_res_if.source              result,
	input  logic                   attr_wr_en,
	input  logic [tcw_pkg::BYTE_W-1:0] attr_wr_data
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
	localparam logic [RW:0]   ROWS_X     = (RW + 1)'(ROWS);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0] COL_LAST_A = AW'(COLUMNS - 1);
	localparam logic [AW-1:0] CELL_LAST  = AW'(CELLS - 1);

	state_t st_q, st_d;

	logic [RW-1:0]     cursor_row_q;
	logic [CW-1:0]     cursor_col_q;
	logic [RW-1:0]     top_q;
	logic [BYTE_W-1:0] attr_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     sweep_last_q;
	logic [CELL_W-1:0] wdata_q;
	logic [1:0]        step_q;
	logic              res_valid_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [BYTE_W-1:0] code_q;
	logic [BYTE_W-1:0] cattr_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic [CELL_W-1:0] cell_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;
	logic [CELL_W-1:0] res_cell_q;

	logic [CELL_W-1:0] rdata;
	logic              accept;
	logic              ram_we;
	logic              res_load;
	logic              step_adv;
	logic              op_last;
	op_t               op;
	logic [BYTE_W-1:0] put_code;
	logic [BYTE_W-1:0] put_attr;
	logic              scroll;
	logic              rd_in_range;
	logic [CW-1:0]     back_col;
	logic [CW-1:0]     col_dec;
	logic [RW-1:0]     row_sel;
	logic [CW-1:0]     col_sel;
	logic [RW:0]       phys_sum;
	logic [RW-1:0]     phys_row;
	logic [AW-1:0]     unit_addr;
	logic [CELL_W-1:0] blank;

	assign accept        = command.valid && command.ready;
	assign command.ready = (st_q == ST_IDLE);
	assign res_load      = (st_q == ST_DONE) && (!res_valid_q || result.ready);
	assign ram_we        = (st_q == ST_WRITE) || (st_q == ST_SWEEP) || (st_q == ST_INIT);
	assign blank         = {attr_q, BLANK_CODE};

	assign result.valid      = res_valid_q;
	assign result.row_now    = res_row_q;
	assign result.column_now = res_col_q;
	assign result.cell_value = res_cell_q;

	// Micro-operation of the current step; enter is two newlines and two puts.
	always_comb begin
		op       = OP_NONE;
		put_code = code_q;
		put_attr = cattr_q;
		case (cmd_q)
			CMD_PUT:     op = OP_PUT;
			CMD_NEWLINE: op = OP_NEWLINE;
			CMD_BACK:    op = OP_BACK;
			CMD_CLEAR:   op = OP_CLEAR;
			CMD_READ:    op = OP_READ;
			CMD_ENTER: begin
				put_attr = PROMPT_ATTR;
				put_code = (step_q == ENTER_LAST_STEP) ? BLANK_CODE : PROMPT_CODE;
				op       = step_q[1] ? OP_PUT : OP_NEWLINE;
			end
			default:     op = OP_NONE;
		endcase
	end

	assign op_last     = !((cmd_q == CMD_ENTER) && (step_q != ENTER_LAST_STEP));
	assign scroll      = (cursor_row_q == ROW_LAST);
	assign rd_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);
	assign col_dec     = cursor_col_q - CW'(1);
	// Backspace never steps back from column two onto prompt column one.
	assign back_col    = (col_dec == CW'(1)) ? CW'(2) : col_dec;

	// Shared address unit: logical row rotated by the top-row pointer.
	always_comb begin
		row_sel = '0;
		col_sel = '0;
		case (op)
			OP_PUT: begin
				row_sel = cursor_row_q;
				col_sel = cursor_col_q;
			end
			OP_BACK: begin
				row_sel = cursor_row_q;
				col_sel = back_col;
			end
			OP_READ: begin
				row_sel = RW'(rrow_q);
				col_sel = CW'(rcol_q);
			end
			default: begin
				row_sel = '0;
				col_sel = '0;
			end
		endcase
	end

	assign phys_sum  = {1'b0, row_sel} + {1'b0, top_q};
	assign phys_row  = (phys_sum >= ROWS_X) ? RW'(phys_sum - ROWS_X) : RW'(phys_sum);
	assign unit_addr = AW'(phys_row) * COLS_A + AW'(col_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		step_adv = 1'b0;
		unique case (st_q)
			ST_INIT: begin
				if (addr_q == CELL_LAST) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op)
					OP_PUT:   st_d = ST_WRITE;
					OP_CLEAR: st_d = ST_SWEEP;
					OP_READ:  st_d = rd_in_range ? ST_RD_ADDR : ST_DONE;
					OP_NEWLINE: begin
						if (scroll) begin
							st_d = ST_SWEEP;
						end else if (op_last) begin
							st_d = ST_DONE;
						end else begin
							st_d     = ST_EXEC;
							step_adv = 1'b1;
						end
					end
					OP_BACK:  st_d = (cursor_col_q == '0) ? ST_DONE : ST_WRITE;
					default:  st_d = ST_DONE;
				endcase
			end
			ST_WRITE: begin
				st_d     = op_last ? ST_DONE : ST_EXEC;
				step_adv = !op_last;
			end
			ST_SWEEP: begin
				if (sweep_q == sweep_last_q) begin
					st_d     = op_last ? ST_DONE : ST_EXEC;
					step_adv = !op_last;
				end
			end
			ST_RD_ADDR: st_d = ST_RD_DATA;
			ST_RD_DATA: st_d = ST_DONE;
			ST_DONE: begin
				if (res_load) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			top_q        <= '0;
			attr_q       <= ATTR_RESET;
			addr_q       <= '0;
			sweep_q      <= '0;
			sweep_last_q <= CELL_LAST;
			wdata_q      <= RESET_BLANK;
			step_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (attr_wr_en) begin
				attr_q <= attr_wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				step_q <= '0;
			end else if (step_adv) begin
				step_q <= step_q + 2'd1;
			end
			unique case (st_q)
				ST_INIT, ST_SWEEP: begin
					addr_q  <= addr_q + AW'(1);
					sweep_q <= sweep_q + AW'(1);
				end
				ST_EXEC: begin
					case (op)
						OP_PUT: begin
							addr_q  <= unit_addr;
							wdata_q <= {put_attr, put_code};
							if (cursor_col_q == COL_LAST) begin
								cursor_col_q <= '0;
								cursor_row_q <= (cursor_row_q == ROW_LAST) ?
									'0 : cursor_row_q + RW'(1);
							end else begin
								cursor_col_q <= cursor_col_q + CW'(1);
							end
						end
						OP_NEWLINE: begin
							cursor_col_q <= '0;
							if (scroll) begin
								// The old top row becomes the blank bottom row.
								addr_q       <= unit_addr;
								wdata_q      <= blank;
								sweep_q      <= '0;
								sweep_last_q <= COL_LAST_A;
								top_q        <= (top_q == ROW_LAST) ? '0 : top_q + RW'(1);
							end else begin
								cursor_row_q <= cursor_row_q + RW'(1);
							end
						end
						OP_BACK: begin
							if (cursor_col_q != '0) begin
								cursor_col_q <= back_col;
								addr_q       <= unit_addr;
								wdata_q      <= blank;
							end
						end
						OP_CLEAR: begin
							addr_q       <= '0;
							wdata_q      <= blank;
							sweep_q      <= '0;
							sweep_last_q <= CELL_LAST;
						end
						OP_READ: begin
							addr_q <= unit_addr;
						end
						default: begin
							addr_q <= addr_q;
						end
					endcase
				end
				default: begin
					addr_q <= addr_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command.cmd;
			code_q  <= command.char_code;
			cattr_q <= command.char_attribute;
			rrow_q  <= command.read_row;
			rcol_q  <= command.read_column;
			cell_q  <= '0;
		end else if (st_q == ST_RD_DATA) begin
			cell_q <= rdata;
		end
		if (res_load) begin
			res_row_q  <= ROW_W'(cursor_row_q);
			res_col_q  <= COL_W'(cursor_col_q);
			res_cell_q <= cell_q;
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(wdata_q),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// A command occupies the sequencer: no second item right after one.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !command.ready)
		else $error("command accepted while the previous one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_col_q <= COL_LAST) && (cursor_row_q <= ROW_LAST) && (top_q <= ROW_LAST))
		else $error("cursor or top-row pointer outside the screen");

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) && !accept |=> $stable(cursor_row_q) && $stable(cursor_col_q))
		else $error("cursor moved without a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (st_q == ST_DONE) && !(res_valid_q && !result.ready))
		else $error("result register overwritten before it was taken");

endmodule

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
